// ===== rtl/hts_pkg.sv =====
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types and constants for the tracked-object speed block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hts_pkg;

  // trace points needed before a speed is measured
  localparam logic [9:0]  MIN_TRACE_POINTS = 10'd12;
  // magnitude bound of a near-zero perspective divisor, Q.16
  localparam int          NEAR_ZERO_W      = 16;
  localparam logic [47:0] SUM_MAX          = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] COUNT_MAX        = 16'hFFFF;
  localparam logic [31:0] SPEED_MAX        = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic [2:0] REG_H_PAIR_A  = 3'd0;
  localparam logic [2:0] REG_H_PAIR_B  = 3'd1;
  localparam logic [2:0] REG_H_PAIR_C  = 3'd2;
  localparam logic [2:0] REG_H_PAIR_D  = 3'd3;
  localparam logic [2:0] REG_H_CORNER  = 3'd4;
  localparam logic [2:0] REG_IMG_WIDTH = 3'd5;
  localparam logic [2:0] REG_IMG_HIGHT = 3'd6;

  // one classified object waiting for the back end
  typedef struct packed {
    logic        speed_ok;
    logic        last;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] ex;
    logic [15:0] ey;
  } item_t;

  // homography entries h00..h22 (row major) and image size
  typedef struct packed {
    logic [8:0][31:0] h;
    logic [13:0]      width;
    logic [13:0]      height;
  } cfg_t;

  // operations of the shared iterative unit
  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_req_t;

endpackage

// ===== rtl/hts_front.sv =====
// ----------------------------------------------------------------------------
// hts_front
// Input stage: registers one object and tags whether its trace is long enough.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hts_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic [9:0]    in_trace_length,
  input  logic [15:0]   in_start_x,
  input  logic [15:0]   in_start_y,
  input  logic [15:0]   in_end_x,
  input  logic [15:0]   in_end_y,
  input  logic          in_last_object,
  output logic          q_push,
  output hts_pkg::item_t q_item,
  input  logic          q_full
);

  logic           vld_r;
  hts_pkg::item_t item_r;
  logic           take;

  // held item moves on whenever the queue has room
  assign q_push  = vld_r && !q_full;
  assign q_item  = item_r;
  assign in_full = vld_r && q_full;
  assign take    = in_push && !in_full;

  // input register with classification
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (q_push) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.speed_ok <= (in_trace_length >= hts_pkg::MIN_TRACE_POINTS);
      item_r.last     <= in_last_object;
      item_r.sx       <= in_start_x;
      item_r.sy       <= in_start_y;
      item_r.ex       <= in_end_x;
      item_r.ey       <= in_end_y;
    end
  end

endmodule

// ===== rtl/hts_queue.sv =====
// ----------------------------------------------------------------------------
// hts_queue
// Two-entry queue between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hts_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hts_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output hts_pkg::item_t pop_item,
  output logic           empty
);

  hts_pkg::item_t slot_r [2];
  logic           wr_r;
  logic           rd_r;
  logic [1:0]     cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_item = slot_r[rd_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_item;
  end

endmodule

// ===== rtl/hts_iter.sv =====
// ----------------------------------------------------------------------------
// hts_iter
// Shared iterative unit: 64/64 unsigned restoring divide (64 steps) or
// 64-bit integer square root (32 steps).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hts_iter (
  input  logic               clk,
  input  logic               rst_n,
  input  hts_pkg::iter_req_t req,
  input  logic [63:0]        a,
  input  logic [63:0]        b,
  output logic               done,
  output logic [63:0]        res
);

  logic              busy_r;
  logic              done_r;
  hts_pkg::iter_op_t op_r;
  logic [6:0]        cnt_r;
  logic [63:0]       q_r;
  logic [63:0]       rem_r;
  logic [63:0]       b_r;
  logic [31:0]       root_r;
  logic [35:0]       srem_r;

  logic [64:0]       sh;
  logic [35:0]       r2;
  logic [35:0]       trial;

  assign done = done_r;
  assign res  = (op_r == hts_pkg::OP_DIV) ? q_r : {32'd0, root_r};

  // one divide step or one root digit
  assign sh    = {rem_r, q_r[63]};
  assign r2    = {srem_r[33:0], q_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 7'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r   <= req.op;
      cnt_r  <= (req.op == hts_pkg::OP_DIV) ? 7'd64 : 7'd32;
      q_r    <= a;
      b_r    <= b;
      rem_r  <= 64'd0;
      root_r <= 32'd0;
      srem_r <= 36'd0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 7'd1;
      unique case (op_r)
        hts_pkg::OP_DIV: begin
          if (sh >= {1'b0, b_r}) begin
            rem_r <= 64'(sh - {1'b0, b_r});
            q_r   <= {q_r[62:0], 1'b1};
          end else begin
            rem_r <= sh[63:0];
            q_r   <= {q_r[62:0], 1'b0};
          end
        end
        hts_pkg::OP_SQRT: begin
          q_r <= {q_r[61:0], 2'b00};
          if (r2 >= trial) begin
            srem_r <= r2 - trial;
            root_r <= {root_r[30:0], 1'b1};
          end else begin
            srem_r <= r2;
            root_r <= {root_r[30:0], 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/hts_back.sv =====
// ----------------------------------------------------------------------------
// hts_back
// Back end sequencer: pixel scaling and homography on one shared multiplier,
// perspective divides and distance root on the iterative unit, then the
// frame sum, count and mean.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hts_back (
  input  logic           clk,
  input  logic           rst_n,
  input  hts_pkg::cfg_t  cfg,
  input  logic           q_empty,
  input  hts_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [31:0]    out_object_speed,
  output logic           out_speed_valid,
  output logic [31:0]    out_average_speed,
  output logic           out_average_valid,
  output logic           out_overflow
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_SCALE = 14'b00000000000010,
    S_MAC   = 14'b00000000000100,
    S_CHK   = 14'b00000000001000,
    S_DIV   = 14'b00000000010000,
    S_DIVW  = 14'b00000000100000,
    S_DIFF  = 14'b00000001000000,
    S_SQ    = 14'b00000010000000,
    S_SQRT  = 14'b00000100000000,
    S_SQRTW = 14'b00001000000000,
    S_ACC   = 14'b00010000000000,
    S_AVG   = 14'b00100000000000,
    S_AVGW  = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t             state_r;
  hts_pkg::item_t     it_r;
  logic [2:0]         step_r;
  logic [29:0]        px_r [4];
  logic signed [65:0] prod_r;
  logic signed [63:0] acc_r;
  logic               i_go_r, c_go_r;
  logic               i_pt_r, c_pt_r;
  logic [1:0]         i_row_r, c_row_r, i_col_r, c_col_r;
  logic [45:0]        num_r [4];
  logic [45:0]        w0_r, w1_r;
  logic [1:0]         d_r;
  logic               neg_r;
  logic [63:0]        m_r [4];
  logic [30:0]        mag_r [2];
  logic [63:0]        sq_r;
  logic [31:0]        speed_r;
  logic [31:0]        avg_r;
  logic               ovf_r;
  logic [47:0]        sum_r;
  logic [15:0]        cnt_r;
  logic               out_vld_r;
  logic [31:0]        o_speed_r, o_avg_r;
  logic               o_sv_r, o_av_r, o_ovf_r;

  logic signed [32:0] mul_a, mul_b;
  hts_pkg::iter_req_t it_req;
  logic [63:0]        it_a, it_b, it_res;
  logic               it_done;
  logic signed [63:0] mac_sum;
  logic [45:0]        num_sel, w_sel, num_mag, w_mag;
  logic signed [63:0] dx, dy;
  logic               dx_ok, dy_ok;
  logic [48:0]        sum_add;
  logic [32:0]        speed2;
  logic               near0, near1;
  logic [3:0]         h_idx;
  logic [1:0]         px_idx;

  // shared iterative unit
  hts_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (it_req),
    .a     (it_a),
    .b     (it_b),
    .done  (it_done),
    .res   (it_res)
  );

  assign q_pop             = (state_r == S_IDLE) && !q_empty;
  assign out_empty         = !out_vld_r;
  assign out_object_speed  = o_speed_r;
  assign out_speed_valid   = o_sv_r;
  assign out_average_speed = o_avg_r;
  assign out_average_valid = o_av_r;
  assign out_overflow      = o_ovf_r;

  // multiplier operand select
  assign h_idx  = 4'({2'b00, i_row_r} * 4'd3 + {2'b00, i_col_r});
  assign px_idx = {i_pt_r, i_col_r[0]};

  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    unique case (state_r)
      S_SCALE: begin
        unique case (step_r)
          3'd0: begin mul_a = $signed({17'd0, it_r.sx}); mul_b = $signed({19'd0, cfg.width}); end
          3'd1: begin mul_a = $signed({17'd0, it_r.sy}); mul_b = $signed({19'd0, cfg.height}); end
          3'd2: begin mul_a = $signed({17'd0, it_r.ex}); mul_b = $signed({19'd0, cfg.width}); end
          3'd3: begin mul_a = $signed({17'd0, it_r.ey}); mul_b = $signed({19'd0, cfg.height}); end
          default: ;
        endcase
      end
      S_MAC: begin
        if (i_go_r) begin
          mul_a = 33'(signed'(cfg.h[h_idx]));
          mul_b = (i_col_r == 2'd2) ? 33'sd65536 : $signed({3'd0, px_r[px_idx]});
        end
      end
      S_SQ: begin
        if (step_r < 3'd2) begin
          mul_a = $signed({2'b00, mag_r[step_r[0]]});
          mul_b = $signed({2'b00, mag_r[step_r[0]]});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // homography accumulate of the product issued last cycle
  assign mac_sum = ((c_col_r == 2'd0) ? 64'sd0 : acc_r) + prod_r[63:0];

  // divide operands as magnitudes
  assign num_sel = num_r[d_r];
  assign w_sel   = d_r[1] ? w1_r : w0_r;
  assign num_mag = num_sel[45] ? 46'(-num_sel) : num_sel;
  assign w_mag   = w_sel[45] ? 46'(-w_sel) : w_sel;

  assign near0 = ($signed(w0_r) > -46'sd16) && ($signed(w0_r) < 46'sd16);
  assign near1 = ($signed(w1_r) > -46'sd16) && ($signed(w1_r) < 46'sd16);

  assign dx    = $signed(m_r[2]) - $signed(m_r[0]);
  assign dy    = $signed(m_r[3]) - $signed(m_r[1]);
  assign dx_ok = (dx > -64'sd2147483648) && (dx < 64'sd2147483648);
  assign dy_ok = (dy > -64'sd2147483648) && (dy < 64'sd2147483648);

  assign sum_add = {1'b0, sum_r} + {17'd0, speed_r};
  assign speed2  = {it_res[31:0], 1'b0};

  // iterative unit requests
  always_comb begin
    it_req.start = 1'b0;
    it_req.op    = hts_pkg::OP_DIV;
    it_a         = {2'b00, num_mag, 16'd0};
    it_b         = {18'd0, w_mag};
    unique case (state_r)
      S_DIV:  it_req.start = 1'b1;
      S_SQRT: begin
        it_req.start = 1'b1;
        it_req.op    = hts_pkg::OP_SQRT;
        it_a         = sq_r;
      end
      S_AVG: begin
        it_req.start = (cnt_r != 16'd0);
        it_a         = {16'd0, sum_r};
        it_b         = {48'd0, cnt_r};
      end
      default: ;
    endcase
  end

  // control sequencer and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      sum_r     <= 48'd0;
      cnt_r     <= 16'd0;
      out_vld_r <= 1'b0;
      i_go_r    <= 1'b0;
      c_go_r    <= 1'b0;
    end else begin
      if (out_pop && out_vld_r) out_vld_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            state_r <= q_item.speed_ok ? S_SCALE : S_ACC;
          end
        end
        S_SCALE: begin
          if (step_r == 3'd4) begin
            state_r <= S_MAC;
            i_go_r  <= 1'b1;
            c_go_r  <= 1'b0;
          end
        end
        S_MAC: begin
          c_go_r <= i_go_r;
          if (i_go_r && i_col_r == 2'd2 && i_row_r == 2'd2 && i_pt_r) i_go_r <= 1'b0;
          if (c_go_r && c_pt_r && c_row_r == 2'd2 && c_col_r == 2'd2) state_r <= S_CHK;
        end
        S_CHK:  state_r <= (near0 || near1) ? S_ACC : S_DIV;
        S_DIV:  state_r <= S_DIVW;
        S_DIVW: begin
          if (it_done) state_r <= (d_r == 2'd3) ? S_DIFF : S_DIV;
        end
        S_DIFF: state_r <= (dx_ok && dy_ok) ? S_SQ : S_ACC;
        S_SQ:   if (step_r == 3'd2) state_r <= S_SQRT;
        S_SQRT: state_r <= S_SQRTW;
        S_SQRTW: if (it_done) state_r <= S_ACC;
        S_ACC: begin
          if (it_r.speed_ok) begin
            sum_r <= (sum_add > {1'b0, hts_pkg::SUM_MAX}) ? hts_pkg::SUM_MAX : sum_add[47:0];
            if (cnt_r != hts_pkg::COUNT_MAX) cnt_r <= cnt_r + 16'd1;
          end
          state_r <= it_r.last ? S_AVG : S_DONE;
        end
        S_AVG: begin
          if (cnt_r == 16'd0) begin
            sum_r   <= 48'd0;
            state_r <= S_DONE;
          end else begin
            state_r <= S_AVGW;
          end
        end
        S_AVGW: begin
          if (it_done) begin
            sum_r   <= 48'd0;
            cnt_r   <= 16'd0;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_vld_r) begin
            out_vld_r <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        it_r    <= q_item;
        step_r  <= 3'd0;
        speed_r <= 32'd0;
        avg_r   <= 32'd0;
        ovf_r   <= 1'b0;
        d_r     <= 2'd0;
        i_pt_r  <= 1'b0;
        i_row_r <= 2'd0;
        i_col_r <= 2'd0;
      end
      S_SCALE: begin
        step_r <= step_r + 3'd1;
        if (step_r != 3'd0) px_r[2'(step_r - 3'd1)] <= prod_r[29:0];
      end
      S_MAC: begin
        c_pt_r  <= i_pt_r;
        c_row_r <= i_row_r;
        c_col_r <= i_col_r;
        // issue counters over point, row, column
        if (i_go_r) begin
          if (i_col_r == 2'd2) begin
            i_col_r <= 2'd0;
            if (i_row_r == 2'd2) begin
              i_row_r <= 2'd0;
              i_pt_r  <= 1'b1;
            end else begin
              i_row_r <= i_row_r + 2'd1;
            end
          end else begin
            i_col_r <= i_col_r + 2'd1;
          end
        end
        if (c_go_r) begin
          acc_r <= mac_sum;
          // floor to Q.16 at the end of each row
          if (c_col_r == 2'd2) begin
            if (c_row_r == 2'd2) begin
              if (c_pt_r) w1_r <= mac_sum[63:18];
              else        w0_r <= mac_sum[63:18];
            end else begin
              num_r[{c_pt_r, c_row_r[0]}] <= mac_sum[63:18];
            end
          end
        end
      end
      S_CHK: begin
        if (near0 || near1) begin
          speed_r <= hts_pkg::SPEED_MAX;
          ovf_r   <= 1'b1;
        end
      end
      S_DIV: neg_r <= num_sel[45] ^ w_sel[45];
      S_DIVW: begin
        if (it_done) begin
          m_r[d_r] <= neg_r ? 64'(-it_res) : it_res;
          d_r      <= d_r + 2'd1;
        end
      end
      S_DIFF: begin
        step_r <= 3'd0;
        mag_r[0] <= dx[63] ? 31'(-dx) : dx[30:0];
        mag_r[1] <= dy[63] ? 31'(-dy) : dy[30:0];
        if (!(dx_ok && dy_ok)) begin
          speed_r <= hts_pkg::SPEED_MAX;
          ovf_r   <= 1'b1;
        end
      end
      S_SQ: begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd1) sq_r <= prod_r[63:0];
        if (step_r == 3'd2) sq_r <= sq_r + prod_r[63:0];
      end
      S_SQRTW: begin
        if (it_done) begin
          if (speed2[32]) begin
            speed_r <= hts_pkg::SPEED_MAX;
            ovf_r   <= 1'b1;
          end else begin
            speed_r <= speed2[31:0];
          end
        end
      end
      S_ACC: begin
        if (it_r.speed_ok &&
            ((sum_add > {1'b0, hts_pkg::SUM_MAX}) || (cnt_r == hts_pkg::COUNT_MAX))) begin
          ovf_r <= 1'b1;
        end
      end
      S_AVGW: begin
        if (it_done) begin
          if (it_res[63:32] != 32'd0) begin
            avg_r <= hts_pkg::SPEED_MAX;
            ovf_r <= 1'b1;
          end else begin
            avg_r <= it_res[31:0];
          end
        end
      end
      S_DONE: begin
        if (!out_vld_r) begin
          o_speed_r <= speed_r;
          o_sv_r    <= it_r.speed_ok;
          o_avg_r   <= avg_r;
          o_av_r    <= it_r.last;
          o_ovf_r   <= ovf_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/homography_track_speed.sv =====
// ----------------------------------------------------------------------------
// homography_track_speed
// Speed of tracked objects through a plane homography, with frame mean.
//
//   channel  ports                     transfer when
//   input    in_push / in_full         in_push && !in_full
//   result   out_pop / out_empty       out_pop && !out_empty
//   config   cfg_valid / cfg_ready     cfg_valid && cfg_ready (always ready)
//
// A qualifying object runs four perspective divides (64 steps each) and a
// root (32 steps) on the shared iterative unit, with the pixel scaling,
// homography and squares on the shared multiplier. A last object adds the
// mean divide. A short object skips the mapping and distance steps.
// Reset (synchronous, rst_n low) clears the frame sum, count and all queues.
// The front register and a two-entry queue keep taking objects while the
// back end works or its result waits to be popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module homography_track_speed (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [9:0]  in_trace_length,
  input  logic [15:0] in_start_x,
  input  logic [15:0] in_start_y,
  input  logic [15:0] in_end_x,
  input  logic [15:0] in_end_y,
  input  logic        in_last_object,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_object_speed,
  output logic        out_speed_valid,
  output logic [31:0] out_average_speed,
  output logic        out_average_valid,
  output logic        out_overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  hts_pkg::cfg_t  cfg_r;
  hts_pkg::item_t f_item, q_item;
  logic           f_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.h      <= {32'h0004_0000, 32'd0, 32'd0, 32'd0, 32'h0004_0000,
                       32'd0, 32'd0, 32'd0, 32'h0004_0000};
      cfg_r.width  <= 14'd1920;
      cfg_r.height <= 14'd1080;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hts_pkg::REG_H_PAIR_A:  begin cfg_r.h[0] <= cfg_data[31:0]; cfg_r.h[1] <= cfg_data[63:32]; end
        hts_pkg::REG_H_PAIR_B:  begin cfg_r.h[2] <= cfg_data[31:0]; cfg_r.h[3] <= cfg_data[63:32]; end
        hts_pkg::REG_H_PAIR_C:  begin cfg_r.h[4] <= cfg_data[31:0]; cfg_r.h[5] <= cfg_data[63:32]; end
        hts_pkg::REG_H_PAIR_D:  begin cfg_r.h[6] <= cfg_data[31:0]; cfg_r.h[7] <= cfg_data[63:32]; end
        hts_pkg::REG_H_CORNER:  cfg_r.h[8]   <= cfg_data[31:0];
        hts_pkg::REG_IMG_WIDTH: cfg_r.width  <= cfg_data[13:0];
        hts_pkg::REG_IMG_HIGHT: cfg_r.height <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  hts_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_trace_length (in_trace_length),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_last_object  (in_last_object),
    .q_push          (f_push),
    .q_item          (f_item),
    .q_full          (q_full)
  );

  hts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .empty     (q_empty)
  );

  hts_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_object_speed  (out_object_speed),
    .out_speed_valid   (out_speed_valid),
    .out_average_speed (out_average_speed),
    .out_average_valid (out_average_valid),
    .out_overflow      (out_overflow)
  );

endmodule

// ===== sim/homography_track_speed_tb.sv =====
// ----------------------------------------------------------------------------
// homography_track_speed_tb
// Self-checking bench for the tracked-object speed block. Objects are pushed
// through several homography and image-size settings, each accepted object
// is run through a bit-exact software model of the mapping, distance and
// frame mean, and every popped result is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module homography_track_speed_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 3000;
  localparam int ITEMS_PER_PHASE = 330;

  // one tracked object as pushed
  typedef struct {
    logic [9:0]  tlen;
    logic [15:0] sx, sy, ex, ey;
    logic        last;
  } track_obj_t;

  // one speed result as popped
  typedef struct {
    logic [31:0] speed;
    logic        speed_ok;
    logic [31:0] avg;
    logic        avg_ok;
    logic        ovf;
  } speed_res_t;

  // speed model plus queue of predicted results
  class speed_scoreboard;
    logic signed [31:0] hm[9];
    logic [13:0]        img_w, img_h;
    longint unsigned    frame_sum;
    int unsigned        frame_count;
    speed_res_t         pending_speeds[$];
    int                 errors, results_seen, ovf_seen, frames_seen;

    function new();
      foreach (hm[i]) hm[i] = 0;
      hm[0] = 32'sd262144;
      hm[4] = 32'sd262144;
      hm[8] = 32'sd262144;
      img_w = 14'd1920;
      img_h = 14'd1080;
      frame_sum = 0;
      frame_count = 0;
    endfunction

    function void apply_config(logic [2:0] idx, logic [63:0] val);
      case (idx)
        hts_pkg::REG_H_PAIR_A: begin hm[0] = val[31:0]; hm[1] = val[63:32]; end
        hts_pkg::REG_H_PAIR_B: begin hm[2] = val[31:0]; hm[3] = val[63:32]; end
        hts_pkg::REG_H_PAIR_C: begin hm[4] = val[31:0]; hm[5] = val[63:32]; end
        hts_pkg::REG_H_PAIR_D: begin hm[6] = val[31:0]; hm[7] = val[63:32]; end
        hts_pkg::REG_H_CORNER: hm[8] = val[31:0];
        hts_pkg::REG_IMG_WIDTH: img_w = val[13:0];
        hts_pkg::REG_IMG_HIGHT: img_h = val[13:0];
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // project one normalized point, returns 1 on a near-zero divisor
    function bit project_point(logic [15:0] nx, logic [15:0] ny,
                               output longint mx, output longint my);
      longint px, py, hx, hy, hw, fx, fy, fw;
      px = longint'(nx) * longint'(img_w);
      py = longint'(ny) * longint'(img_h);
      hx = longint'(hm[0]) * px + longint'(hm[1]) * py + longint'(hm[2]) * 65536;
      hy = longint'(hm[3]) * px + longint'(hm[4]) * py + longint'(hm[5]) * 65536;
      hw = longint'(hm[6]) * px + longint'(hm[7]) * py + longint'(hm[8]) * 65536;
      fx = hx >>> 18;
      fy = hy >>> 18;
      fw = hw >>> 18;
      mx = 0;
      my = 0;
      if (fw > -hts_pkg::NEAR_ZERO_W && fw < hts_pkg::NEAR_ZERO_W) return 1'b1;
      mx = (fx * 65536) / fw;
      my = (fy * 65536) / fw;
      return 1'b0;
    endfunction

    function void note_object(track_obj_t o);
      speed_res_t r;
      longint bx, by, ex, ey, dx, dy;
      longint unsigned sp, sq, av;
      bit z1, z2;
      sp = 0;
      av = 0;
      r.ovf = 1'b0;
      r.speed_ok = (o.tlen >= hts_pkg::MIN_TRACE_POINTS);
      if (r.speed_ok) begin
        z1 = project_point(o.sx, o.sy, bx, by);
        z2 = project_point(o.ex, o.ey, ex, ey);
        if (z1 || z2) begin
          sp = hts_pkg::SPEED_MAX;
          r.ovf = 1'b1;
        end else begin
          dx = ex - bx;
          dy = ey - by;
          if (dx <= -64'sd2147483648 || dx >= 64'sd2147483648 ||
              dy <= -64'sd2147483648 || dy >= 64'sd2147483648) begin
            sp = hts_pkg::SPEED_MAX;
            r.ovf = 1'b1;
          end else begin
            sq = longint'(dx * dx) + longint'(dy * dy);
            sp = 2 * int_sqrt(sq);
            if (sp > hts_pkg::SPEED_MAX) begin
              sp = hts_pkg::SPEED_MAX;
              r.ovf = 1'b1;
            end
          end
        end
        if (frame_sum + sp > hts_pkg::SUM_MAX) begin
          frame_sum = hts_pkg::SUM_MAX;
          r.ovf = 1'b1;
        end else begin
          frame_sum = frame_sum + sp;
        end
        if (frame_count >= hts_pkg::COUNT_MAX) r.ovf = 1'b1;
        else frame_count++;
      end
      // frame end: mean, then clear
      if (o.last) begin
        if (frame_count != 0) begin
          av = frame_sum / frame_count;
          if (av > hts_pkg::SPEED_MAX) begin
            av = hts_pkg::SPEED_MAX;
            r.ovf = 1'b1;
          end
        end
        frame_sum = 0;
        frame_count = 0;
      end
      r.speed = sp[31:0];
      r.avg = av[31:0];
      r.avg_ok = o.last;
      pending_speeds.insert(pending_speeds.size(), r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH result %0d %s: got %h want %h", results_seen, what, got, want);
    endtask

    task check_result(speed_res_t got);
      speed_res_t want;
      results_seen++;
      if (got.ovf) ovf_seen++;
      if (got.avg_ok) frames_seen++;
      if (pending_speeds.size() == 0) begin
        report("unexpected result", got.speed, 32'h0);
      end else begin
        want = pending_speeds.pop_front();
        if (got.speed !== want.speed) report("object_speed", got.speed, want.speed);
        if (got.speed_ok !== want.speed_ok)
          report("speed_valid", 32'(got.speed_ok), 32'(want.speed_ok));
        if (got.avg !== want.avg) report("average_speed", got.avg, want.avg);
        if (got.avg_ok !== want.avg_ok)
          report("average_valid", 32'(got.avg_ok), 32'(want.avg_ok));
        if (got.ovf !== want.ovf) report("overflow", 32'(got.ovf), 32'(want.ovf));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [9:0]  in_trace_length = '0;
  logic [15:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic        in_last_object = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [31:0] out_object_speed, out_average_speed;
  logic        out_speed_valid, out_average_valid, out_overflow;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  speed_scoreboard sb = new();
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;

  homography_track_speed u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_trace_length(in_trace_length), .in_start_x(in_start_x),
    .in_start_y(in_start_y), .in_end_x(in_end_x), .in_end_y(in_end_y),
    .in_last_object(in_last_object),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_object_speed(out_object_speed), .out_speed_valid(out_speed_valid),
    .out_average_speed(out_average_speed), .out_average_valid(out_average_valid),
    .out_overflow(out_overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // result transfers go to the scoreboard
  always @(posedge clk) begin
    speed_res_t r;
    if (rst_n && out_pop && !out_empty) begin
      r.speed = out_object_speed;
      r.speed_ok = out_speed_valid;
      r.avg = out_average_speed;
      r.avg_ok = out_average_valid;
      r.ovf = out_overflow;
      sb.check_result(r);
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", sb.pending_speeds.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: pops with random idle bursts and one long hold-off
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task push_object(track_obj_t o);
    in_trace_length <= o.tlen;
    in_start_x <= o.sx;
    in_start_y <= o.sy;
    in_end_x <= o.ex;
    in_end_y <= o.ey;
    in_last_object <= o.last;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    sb.note_object(o);
    items_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task stop_pushing();
    in_push <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every result is back, then let the back end settle
  task drain();
    while (sb.pending_speeds.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.apply_config(idx, val);
    cfg_writes++;
  endtask

  function automatic logic [31:0] rand_q(int unsigned span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  // entries within +-span of identity, corner +-span/4, perspective +-pspan
  task load_homography(int unsigned span, int unsigned pspan);
    write_reg(hts_pkg::REG_H_PAIR_A, {rand_q(span), rand_q(span) + 32'sd262144});
    write_reg(hts_pkg::REG_H_PAIR_B, {rand_q(span), rand_q(span)});
    write_reg(hts_pkg::REG_H_PAIR_C, {rand_q(span), rand_q(span) + 32'sd262144});
    write_reg(hts_pkg::REG_H_PAIR_D, {rand_q(pspan), rand_q(pspan)});
    write_reg(hts_pkg::REG_H_CORNER, {32'h0, rand_q(span / 4) + 32'sd262144});
  endtask

  function automatic track_obj_t make_obj(int tl, int sx, int sy, int ex, int ey,
                                          bit lst);
    track_obj_t o;
    o.tlen = 10'(tl); o.sx = 16'(sx); o.sy = 16'(sy);
    o.ex = 16'(ex); o.ey = 16'(ey); o.last = lst;
    return o;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic track_obj_t rand_obj();
    track_obj_t o;
    case ($urandom_range(0, 9))
      0: o.tlen = 10'($urandom_range(0, 11));
      1: o.tlen = 10'($urandom_range(0, 1023));
      default: o.tlen = 10'($urandom_range(12, 1023));
    endcase
    o.sx = rand_coord();
    o.sy = rand_coord();
    o.ex = rand_coord();
    o.ey = rand_coord();
    o.last = ($urandom_range(0, 7) == 0);
    return o;
  endfunction

  task random_objects(int n);
    repeat (n) push_object(rand_obj());
    push_object(make_obj($urandom_range(0, 1023), 0, 0, 0, 0, 1'b1));
    stop_pushing();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, field extremes and frame cases
    push_object(make_obj(0, 0, 0, 16'hFFFF, 16'hFFFF, 1'b0));
    push_object(make_obj(11, 0, 0, 16'hFFFF, 16'hFFFF, 1'b0));
    push_object(make_obj(12, 0, 0, 16'hFFFF, 16'hFFFF, 1'b0));
    push_object(make_obj(1023, 16'hFFFF, 16'hFFFF, 0, 0, 1'b0));
    push_object(make_obj(12, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1));
    push_object(make_obj(5, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b1));
    push_object(make_obj(1023, 0, 16'hFFFF, 16'hFFFF, 0, 1'b1));
    push_object(make_obj(1, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 1'b0));
    push_object(make_obj(512, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b1));
    stop_pushing();
    drain();

    // directed: zero divisor everywhere and largest image
    write_reg(hts_pkg::REG_H_PAIR_D, 64'h0);
    write_reg(hts_pkg::REG_H_CORNER, 64'h0);
    write_reg(hts_pkg::REG_IMG_WIDTH, 64'd8192);
    write_reg(hts_pkg::REG_IMG_HIGHT, 64'd8192);
    push_object(make_obj(12, 0, 0, 16'hFFFF, 16'hFFFF, 1'b0));
    push_object(make_obj(3, 0, 0, 16'hFFFF, 16'hFFFF, 1'b1));
    stop_pushing();
    drain();

    // directed: extreme entries and a near-zero divisor, smallest image
    write_reg(hts_pkg::REG_H_PAIR_A, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
    write_reg(hts_pkg::REG_H_PAIR_B, {32'h8000_0000, 32'h8000_0000});
    write_reg(hts_pkg::REG_H_PAIR_C, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
    write_reg(hts_pkg::REG_H_PAIR_D, 64'h0);
    write_reg(hts_pkg::REG_H_CORNER, 64'd16);
    push_object(make_obj(12, 0, 0, 16'hFFFF, 16'hFFFF, 1'b0));
    push_object(make_obj(1023, 16'hFFFF, 0, 0, 16'hFFFF, 1'b1));
    stop_pushing();
    drain();
    write_reg(hts_pkg::REG_IMG_WIDTH, 64'd1);
    write_reg(hts_pkg::REG_IMG_HIGHT, 64'd1);
    push_object(make_obj(12, 0, 0, 16'hFFFF, 16'hFFFF, 1'b1));
    stop_pushing();
    drain();

    // phase: affine map, largest image
    load_homography(1 << 19, 0);
    write_reg(hts_pkg::REG_IMG_WIDTH, 64'd8192);
    write_reg(hts_pkg::REG_IMG_HIGHT, 64'd8192);
    random_objects(ITEMS_PER_PHASE);
    drain();

    // phase: perspective map, random image size, receiver holds off
    load_homography(1 << 18, 1 << 6);
    write_reg(hts_pkg::REG_IMG_WIDTH, 64'($urandom_range(1, 8192)));
    write_reg(hts_pkg::REG_IMG_HIGHT, 64'($urandom_range(1, 8192)));
    hold_req = 1'b1;
    random_objects(ITEMS_PER_PHASE);
    drain();

    // phase: tiny divisor, many near-zero and saturated points
    load_homography(1 << 20, 1 << 12);
    write_reg(hts_pkg::REG_H_CORNER, 64'($urandom_range(0, 64)));
    random_objects(ITEMS_PER_PHASE);
    drain();

    // phase: homography entries random in all bits, random image size
    write_reg(hts_pkg::REG_H_PAIR_A, {$urandom, $urandom});
    write_reg(hts_pkg::REG_H_PAIR_B, {$urandom, $urandom});
    write_reg(hts_pkg::REG_H_PAIR_C, {$urandom, $urandom});
    write_reg(hts_pkg::REG_H_PAIR_D, {$urandom, $urandom});
    write_reg(hts_pkg::REG_H_CORNER, {$urandom, $urandom});
    write_reg(hts_pkg::REG_IMG_WIDTH, 64'($urandom_range(1, 8192)));
    write_reg(hts_pkg::REG_IMG_HIGHT, 64'($urandom_range(1, 8192)));
    random_objects(ITEMS_PER_PHASE);
    drain();

    // phase: moderate map, no idling on either side
    load_homography(1 << 17, 1 << 4);
    write_reg(hts_pkg::REG_IMG_WIDTH, 64'd1920);
    write_reg(hts_pkg::REG_IMG_HIGHT, 64'd1080);
    idle_on = 1'b0;
    random_objects(ITEMS_PER_PHASE);
    drain();

    $display("covered %0d objects in %0d frames over %0d register writes",
             items_sent, sb.frames_seen, cfg_writes);
    $display("results checked %0d, with overflow flagged %0d, errors %0d",
             sb.results_seen, sb.ovf_seen, sb.errors);
    if (sb.errors == 0 && sb.pending_speeds.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hts_pkg.sv
rtl/hts_front.sv
rtl/hts_queue.sv
rtl/hts_iter.sv
rtl/hts_back.sv
rtl/homography_track_speed.sv
sim/homography_track_speed_tb.sv
